// ===== rtl/rc4_pkg.sv =====
// rc4 stream cipher: shared constants, codes and interface types
// no dependencies; imported by every rtl module of the block
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES = 16;
  localparam int unsigned KEY_BYTES     = 16;
  localparam int unsigned KEY_IDX_W     = 4;
  localparam int unsigned LEN_W         = 5;
  localparam int unsigned SBOX_DEPTH    = 256;
  localparam int unsigned SBOX_AW       = 8;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW    = 2'd0,
    CFG_KEY_HIGH   = 2'd1,
    CFG_KEY_LENGTH = 2'd2
  } cfg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_INIT = 8'b0000_0010,
    ST_K0   = 8'b0000_0100,
    ST_K1   = 8'b0000_1000,
    ST_K2   = 8'b0001_0000,
    ST_P0   = 8'b0010_0000,
    ST_P1   = 8'b0100_0000,
    ST_P2   = 8'b1000_0000
  } state_e;

  // key bytes and effective key length (1 .. MAX_KEY_BYTES)
  typedef struct packed {
    logic [KEY_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]          len;
  } key_t;

  // s-box memory access for one cycle
  typedef struct packed {
    logic               we;
    logic [SBOX_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [SBOX_AW-1:0] raddr;
  } ram_req_t;

endpackage

// ===== rtl/rc4_cfg.sv =====
// rc4 configuration registers: key bytes and key length
// depends on rc4_pkg; feeds the key to rc4_ctrl
module rc4_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output rc4_pkg::key_t                    key_o
);
  import rc4_pkg::*;

  logic [63:0]      key_low_q;
  logic [63:0]      key_high_q;
  logic [LEN_W-1:0] key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= LEN_W'(KEY_BYTES);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KEY_LOW:    key_low_q  <= cfg_wdata_i[63:0];
        CFG_KEY_HIGH:   key_high_q <= cfg_wdata_i[63:0];
        CFG_KEY_LENGTH: key_len_q  <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    key_o.bytes = {key_high_q, key_low_q};
    if (key_len_q == '0) begin
      key_o.len = LEN_W'(1);
    end else if (key_len_q > LEN_W'(MAX_KEY_BYTES)) begin
      key_o.len = LEN_W'(MAX_KEY_BYTES);
    end else begin
      key_o.len = key_len_q;
    end
  end

endmodule

// ===== rtl/rc4_sbox_ram.sv =====
// rc4 s-box store: 256 x 8 synchronous memory, one write and one read port
// depends on rc4_pkg; read data registered, a same-address write is passed through
module rc4_sbox_ram (
  input  logic              clk_i,
  input  rc4_pkg::ram_req_t req_i,
  output logic [7:0]        rdata_o
);
  import rc4_pkg::*;

  logic [7:0] mem [SBOX_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      if (req_i.we && (req_i.waddr == req_i.raddr)) begin
        rdata_q <= req_i.wdata;
      end else begin
        rdata_q <= mem[req_i.raddr];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rc4_ctrl.sv =====
// rc4 sequencer: key schedule, keystream step, deferred swap write and output word
// depends on rc4_pkg; drives rc4_sbox_ram and takes the key from rc4_cfg
module rc4_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              start_of_message_i,
  input  rc4_pkg::key_t     key_i,
  output rc4_pkg::ram_req_t ram_req_o,
  input  logic [7:0]        ram_rdata_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o
);
  import rc4_pkg::*;

  state_e state_q, state_d;

  logic [7:0]           n_q, n_d;
  logic [7:0]           i_q, i_d;
  logic [7:0]           j_q, j_d;
  logic [7:0]           s_q, s_d;
  logic [7:0]           t_q, t_d;
  logic [7:0]           data_q, data_d;
  logic [7:0]           out_q, out_d;
  logic [7:0]           pw_addr_q, pw_addr_d;
  logic [7:0]           pw_data_q, pw_data_d;
  logic [KEY_IDX_W-1:0] kidx_q, kidx_d;
  logic                 keyed_q, keyed_d;
  logic                 pw_valid_q, pw_valid_d;
  logic                 fin_q, fin_d;
  logic                 out_valid_q, out_valid_d;

  logic       out_free;
  logic       kidx_last;
  logic       dir_we;
  logic [7:0] dir_waddr;
  logic [7:0] dir_wdata;
  logic [7:0] sum_j;
  logic [7:0] ks;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;
  assign kidx_last   = ({1'b0, kidx_q} == (key_i.len - LEN_W'(1)));
  // swap partner write is still pending when the keystream index hits it
  assign ks          = (t_q == j_q) ? s_q : ram_rdata_i;
  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_q;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    s_d         = s_q;
    t_d         = t_q;
    data_d      = data_q;
    out_d       = out_q;
    pw_addr_d   = pw_addr_q;
    pw_data_d   = pw_data_q;
    kidx_d      = kidx_q;
    keyed_d     = keyed_q;
    pw_valid_d  = 1'b0;
    fin_d       = 1'b0;
    out_valid_d = out_valid_q;
    dir_we      = 1'b0;
    dir_waddr   = n_q;
    dir_wdata   = n_q;
    sum_j       = j_q + ram_rdata_i;
    ram_req_o.re    = 1'b0;
    ram_req_o.raddr = i_q + 8'd1;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (fin_q) begin
      out_valid_d = 1'b1;
      out_d       = data_q ^ ks;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          data_d = data_byte_i;
          if (start_of_message_i || !keyed_q) begin
            n_d     = '0;
            i_d     = '0;
            j_d     = '0;
            kidx_d  = '0;
            state_d = ST_INIT;
          end else begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = i_q + 8'd1;
            i_d             = i_q + 8'd1;
            state_d         = ST_P1;
          end
        end
      end
      ST_INIT: begin
        dir_we    = 1'b1;
        dir_waddr = n_q;
        dir_wdata = n_q;
        n_d       = n_q + 8'd1;
        if (n_q == 8'hFF) begin
          state_d = ST_K0;
        end
      end
      ST_K0: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = n_q;
        state_d         = ST_K1;
      end
      ST_K1: begin
        sum_j           = j_q + ram_rdata_i + key_i.bytes[kidx_q];
        j_d             = sum_j;
        s_d             = ram_rdata_i;
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = sum_j;
        state_d         = ST_K2;
      end
      ST_K2: begin
        dir_we     = 1'b1;
        dir_waddr  = n_q;
        dir_wdata  = ram_rdata_i;
        pw_valid_d = 1'b1;
        pw_addr_d  = j_q;
        pw_data_d  = s_q;
        n_d        = n_q + 8'd1;
        kidx_d     = kidx_last ? '0 : kidx_q + KEY_IDX_W'(1);
        if (n_q == 8'hFF) begin
          j_d     = '0;
          keyed_d = 1'b1;
          state_d = ST_P0;
        end else begin
          state_d = ST_K0;
        end
      end
      ST_P0: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = i_q + 8'd1;
        i_d             = i_q + 8'd1;
        state_d         = ST_P1;
      end
      ST_P1: begin
        sum_j           = j_q + ram_rdata_i;
        j_d             = sum_j;
        s_d             = ram_rdata_i;
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = sum_j;
        state_d         = ST_P2;
      end
      ST_P2: begin
        if (out_free) begin
          dir_we          = 1'b1;
          dir_waddr       = i_q;
          dir_wdata       = ram_rdata_i;
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = s_q + ram_rdata_i;
          t_d             = s_q + ram_rdata_i;
          pw_valid_d      = 1'b1;
          pw_addr_d       = j_q;
          pw_data_d       = s_q;
          fin_d           = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    ram_req_o.we    = dir_we || pw_valid_q;
    ram_req_o.waddr = dir_we ? dir_waddr : pw_addr_q;
    ram_req_o.wdata = dir_we ? dir_wdata : pw_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      kidx_q      <= '0;
      keyed_q     <= 1'b0;
      pw_valid_q  <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      kidx_q      <= kidx_d;
      keyed_q     <= keyed_d;
      pw_valid_q  <= pw_valid_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q       <= s_d;
    t_q       <= t_d;
    data_q    <= data_d;
    out_q     <= out_d;
    pw_addr_q <= pw_addr_d;
    pw_data_q <= pw_data_d;
  end

  a_pw_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pw_valid_q |-> !dir_we)
    else $error("deferred swap write collides with a direct write");

  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> (state_q == ST_IDLE) && !out_valid_q)
    else $error("result word finished while output register is occupied");

  a_fin_after_p2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> $past(state_q == ST_P2))
    else $error("result word finished without a keystream step");

  a_step_keyed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P1) |-> keyed_q)
    else $error("keystream step before any key schedule");

  a_ksa_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_K0) && $past(state_q == ST_INIT)) |-> (n_q == 8'd0) && (j_q == 8'd0))
    else $error("key scrambling does not start at entry zero");

endmodule

// ===== rtl/rc4_stream_cipher.sv =====
// rc4 stream cipher top level: byte in, byte xor keystream out
// depends on rc4_pkg, rc4_cfg, rc4_sbox_ram and rc4_ctrl
// an accepted word passes states P1 and P2 and the finish register to the output register;
// P2 waits for a free output register; the next word is taken only after the last left P2,
// bound by the single read port of the s-box memory; a key schedule on start of message or
// the first word after reset first does 256 identity writes and 256 K0-K1-K2 scramble steps
// reset clears control state and key bytes, length to 16; s-box unknown until scheduled
module rc4_stream_cipher (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           start_of_message_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     out_byte_o
);
  import rc4_pkg::*;

  key_t       key;
  ram_req_t   ram_req;
  logic [7:0] ram_rdata;

  rc4_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .key_o       (key)
  );

  rc4_sbox_ram u_sbox (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  rc4_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .data_byte_i        (data_byte_i),
    .start_of_message_i (start_of_message_i),
    .key_i              (key),
    .ram_req_o          (ram_req),
    .ram_rdata_i        (ram_rdata),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .out_byte_o         (out_byte_o)
  );

endmodule
